>>> src/dual_wheel_speed_pid_assert.svh
// Assertion macros shared by the speed controller.
`ifndef DUAL_WHEEL_SPEED_PID_ASSERT_SVH
`define DUAL_WHEEL_SPEED_PID_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define DWSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define DWSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> src/dwsp_pkg.sv
// ----------------------------------------------------------------------------
// dwsp_pkg
// Shared types and constants of the dual wheel speed controller.
// ----------------------------------------------------------------------------
package dwsp_pkg;

    localparam int unsigned FiltOld    = 45875;
    localparam int unsigned FiltNew    = 19661;
    localparam int          IntegLimit = 20480;
    localparam int          DriveLimit = 1023;

    localparam logic [2:0] RegKp     = 3'd0;
    localparam logic [2:0] RegKi     = 3'd1;
    localparam logic [2:0] RegKd     = 3'd2;
    localparam logic [2:0] RegScale  = 3'd3;
    localparam logic [2:0] RegPeriod = 3'd4;
    localparam logic [2:0] RegGlitch = 3'd5;
    localparam logic [2:0] RegRamp   = 3'd6;
    localparam logic [2:0] RegDir    = 3'd7;

    // Datapath steps that the controller commands.
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_RAW,      // count * scale
        STEP_FOLD,     // saturate raw, old * FiltOld
        STEP_FNEW,     // raw * FiltNew, add, filter and glitch check
        STEP_RAMP,     // ramp both targets (both wheels at once)
        STEP_ERR,      // err and err * period
        STEP_INTEG,    // integrator update, Kp * err
        STEP_KI,       // Ki * integ
        STEP_KD,       // Kd * (err - last)
        STEP_DRIVE,    // sum, clamp, store drive
        STEP_STOP,     // zero drives, clear loops
        STEP_CLEAR     // reset op
    } t_step;

    typedef struct packed {
        t_step step;
        logic  wheel;     // 0 right, 1 left
        logic  load;      // capture input item
    } t_cmd;

    typedef struct packed {
        logic stop;       // both targets and ramps are zero
    } t_status;

endpackage

>>> src/dual_wheel_speed_pid.sv
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid
// Two wheel speed PID loops with setpoint ramp and filtered speed feedback.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       i_valid / o_ready    i_op, i_count_*, i_target_*
//  out      o_valid / i_ready    o_drive_*, o_speed_*
//  config   APB psel/penable     paddr, pwdata, prdata
//
// Every product of a control tick goes through the one shared 22x22
// multiplier, one step a cycle. When both targets and both ramps are zero
// the PID steps are skipped. A reset op gives no result. Synchronous
// active-low reset. The next item is accepted only after the result has
// been taken.
module dual_wheel_speed_pid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_op,
    input  logic signed [15:0]  i_count_right,
    input  logic signed [15:0]  i_count_left,
    input  logic signed [19:0]  i_target_right,
    input  logic signed [19:0]  i_target_left,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [10:0]  o_drive_right,
    output logic signed [10:0]  o_drive_left,
    output logic signed [19:0]  o_speed_right,
    output logic signed [19:0]  o_speed_left,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    `include "dual_wheel_speed_pid_assert.svh"

    logic [19:0] r_kp, r_ki, r_kd, r_scale;
    logic [15:0] r_period;
    logic [18:0] r_glitch, r_ramp;
    logic [1:0]  r_dir;
    logic        wr_en;
    logic [2:0]  reg_idx;

    dwsp_pkg::t_cmd    cmd;
    dwsp_pkg::t_status status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Configuration registers, reset to the nominal tuning.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= 20'd38400;
            r_ki     <= 20'd153600;
            r_kd     <= 20'd2560;
            r_scale  <= 20'd49942;
            r_period <= 16'd6554;
            r_glitch <= 19'd163840;
            r_ramp   <= 19'd6144;
            r_dir    <= 2'd0;
        end else if (wr_en && (paddr[1:0] == 2'b00)) begin
            case (reg_idx)
                dwsp_pkg::RegKp:     r_kp     <= pwdata[19:0];
                dwsp_pkg::RegKi:     r_ki     <= pwdata[19:0];
                dwsp_pkg::RegKd:     r_kd     <= pwdata[19:0];
                dwsp_pkg::RegScale:  r_scale  <= pwdata[19:0];
                dwsp_pkg::RegPeriod: r_period <= pwdata[15:0];
                dwsp_pkg::RegGlitch: r_glitch <= pwdata[18:0];
                dwsp_pkg::RegRamp:   r_ramp   <= pwdata[18:0];
                dwsp_pkg::RegDir:    r_dir    <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dwsp_pkg::RegKp:     prdata = {12'd0, r_kp};
            dwsp_pkg::RegKi:     prdata = {12'd0, r_ki};
            dwsp_pkg::RegKd:     prdata = {12'd0, r_kd};
            dwsp_pkg::RegScale:  prdata = {12'd0, r_scale};
            dwsp_pkg::RegPeriod: prdata = {16'd0, r_period};
            dwsp_pkg::RegGlitch: prdata = {13'd0, r_glitch};
            dwsp_pkg::RegRamp:   prdata = {13'd0, r_ramp};
            dwsp_pkg::RegDir:    prdata = {30'd0, r_dir};
            default:             prdata = '0;
        endcase
    end

    dwsp_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_op     (i_op),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (cmd),
        .i_status (status)
    );

    dwsp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_op           (i_op),
        .i_count_right  (i_count_right),
        .i_count_left   (i_count_left),
        .i_target_right (i_target_right),
        .i_target_left  (i_target_left),
        .i_kp           (r_kp),
        .i_ki           (r_ki),
        .i_kd           (r_kd),
        .i_scale        (r_scale),
        .i_period       (r_period),
        .i_glitch       (r_glitch),
        .i_ramp         (r_ramp),
        .i_dir          (r_dir),
        .o_drive_right  (o_drive_right),
        .o_drive_left   (o_drive_left),
        .o_speed_right  (o_speed_right),
        .o_speed_left   (o_speed_left)
    );

    // No new item is taken while a result is still waiting.
    `DWSP_ASSERT_IMP(a_no_accept_pending, i_clk, i_rst_n, o_valid, !o_ready)
    // The right drive never leaves the PWM range.
    `DWSP_ASSERT_IMP(a_drive_range, i_clk, i_rst_n, o_valid,
        (o_drive_right <= 11'sd1023) && (o_drive_right >= -11'sd1023))
    // A reset op never produces a result next cycle.
    `DWSP_ASSERT_NEXT(a_clear_silent, i_clk, i_rst_n, i_valid && o_ready && i_op, !o_valid)

endmodule

>>> src/dwsp_datapath.sv
// ----------------------------------------------------------------------------
// dwsp_datapath
// Per-wheel speed filter, ramp and PID around one shared multiplier.
// ----------------------------------------------------------------------------
module dwsp_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dwsp_pkg::t_cmd        i_cmd,
    output dwsp_pkg::t_status     o_status,
    input  logic                  i_op,
    input  logic signed [15:0]    i_count_right,
    input  logic signed [15:0]    i_count_left,
    input  logic signed [19:0]    i_target_right,
    input  logic signed [19:0]    i_target_left,
    input  logic [19:0]           i_kp,
    input  logic [19:0]           i_ki,
    input  logic [19:0]           i_kd,
    input  logic [19:0]           i_scale,
    input  logic [15:0]           i_period,
    input  logic [18:0]           i_glitch,
    input  logic [18:0]           i_ramp,
    input  logic [1:0]            i_dir,
    output logic signed [10:0]    o_drive_right,
    output logic signed [10:0]    o_drive_left,
    output logic signed [19:0]    o_speed_right,
    output logic signed [19:0]    o_speed_left
);

    logic signed [15:0] r_cnt [2];
    logic signed [19:0] r_tgt [2];
    logic signed [19:0] r_filt [2];
    logic signed [19:0] r_ramp [2];
    logic signed [16:0] r_integ [2];
    logic signed [20:0] r_last [2];
    logic signed [10:0] r_drive [2];
    logic signed [19:0] r_raw;
    logic signed [20:0] r_err;
    logic signed [48:0] r_prod;
    logic signed [48:0] r_acc;
    logic               r_stop;

    logic               w;
    logic signed [21:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [48:0] mul_p;
    logic signed [36:0] raw_full;
    logic signed [19:0] raw_sat;
    logic signed [48:0] fsum;
    logic signed [19:0] fnew;
    logic signed [19:0] fabs;
    logic signed [21:0] isum;
    logic signed [16:0] inext;
    logic signed [48:0] dsum;
    logic signed [28:0] dshift;
    logic signed [20:0] rn [2];
    logic signed [20:0] rup [2];
    logic signed [20:0] rdn [2];

    assign w = i_cmd.wheel;

    // Operand select for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.step)
            dwsp_pkg::STEP_RAW: begin
                mul_a = 22'(r_cnt[w]);
                mul_b = 22'($signed({2'b00, i_scale}));
            end
            dwsp_pkg::STEP_FOLD: begin
                mul_a = 22'(r_filt[w]);
                mul_b = 22'(dwsp_pkg::FiltOld);
            end
            dwsp_pkg::STEP_FNEW: begin
                mul_a = 22'(r_raw);
                mul_b = 22'(dwsp_pkg::FiltNew);
            end
            dwsp_pkg::STEP_ERR: begin
                mul_a = 22'(r_ramp[w]) - 22'(r_filt[w]);
                mul_b = 22'($signed({6'd0, i_period}));
            end
            dwsp_pkg::STEP_INTEG: begin
                mul_a = 22'(r_err);
                mul_b = 22'($signed({2'b00, i_kp}));
            end
            dwsp_pkg::STEP_KI: begin
                mul_a = 22'(r_integ[w]);
                mul_b = 22'($signed({2'b00, i_ki}));
            end
            dwsp_pkg::STEP_KD: begin
                mul_a = 22'(r_err) - 22'(r_last[w]);
                mul_b = 22'($signed({2'b00, i_kd}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 49'(mul_a) * 49'(mul_b);

    // Raw speed: product >> 8, optional negate, saturate.
    always_comb begin
        raw_full = 37'(r_prod >>> 8);
        if (i_dir[w]) begin
            raw_full = -raw_full;
        end
        if (raw_full > 37'sd524287) begin
            raw_sat = 20'sd524287;
        end else if (raw_full < -37'sd524288) begin
            raw_sat = -20'sd524288;
        end else begin
            raw_sat = 20'(raw_full);
        end
    end

    // The old-speed product from the previous step is still in r_prod.
    always_comb begin
        fsum = r_prod + mul_p;
        fnew = 20'(fsum >>> 16);
        fabs = (fnew < 0) ? -fnew : fnew;
    end

    always_comb begin
        isum = 22'(r_integ[w]) + 22'(r_prod >>> 16);
        if (isum > 22'(dwsp_pkg::IntegLimit)) begin
            inext = 17'(dwsp_pkg::IntegLimit);
        end else if (isum < -22'(dwsp_pkg::IntegLimit)) begin
            inext = -17'(dwsp_pkg::IntegLimit);
        end else begin
            inext = 17'(isum);
        end
        dsum = r_acc + r_prod;
        dshift = 29'(dsum >>> 20);
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            rup[k] = 21'(r_ramp[k]) + 21'($signed({2'b00, i_ramp}));
            rdn[k] = 21'(r_ramp[k]) - 21'($signed({2'b00, i_ramp}));
            if (r_tgt[k] > r_ramp[k]) begin
                rn[k] = (rup[k] < 21'(r_tgt[k])) ? rup[k] : 21'(r_tgt[k]);
            end else if (r_tgt[k] < r_ramp[k]) begin
                rn[k] = (rdn[k] > 21'(r_tgt[k])) ? rdn[k] : 21'(r_tgt[k]);
            end else begin
                rn[k] = 21'(r_ramp[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_filt[k]  <= '0;
                r_ramp[k]  <= '0;
                r_integ[k] <= '0;
                r_last[k]  <= '0;
                r_drive[k] <= '0;
            end
            r_stop <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt[0] <= i_count_right;
                r_cnt[1] <= i_count_left;
                r_tgt[0] <= i_target_right;
                r_tgt[1] <= i_target_left;
            end
            r_prod <= mul_p;
            case (i_cmd.step)
                dwsp_pkg::STEP_FOLD: begin
                    r_raw <= raw_sat;
                end
                dwsp_pkg::STEP_FNEW: begin
                    r_filt[w] <= ($signed({1'b0, fabs}) > $signed({2'b00, i_glitch}))
                        ? '0 : fnew;
                end
                dwsp_pkg::STEP_RAMP: begin
                    r_ramp[0] <= 20'(rn[0]);
                    r_ramp[1] <= 20'(rn[1]);
                    r_stop <= (r_tgt[0] == 0) && (r_tgt[1] == 0)
                        && (rn[0] == 0) && (rn[1] == 0);
                end
                dwsp_pkg::STEP_ERR: begin
                    r_err <= mul_a[20:0];
                end
                dwsp_pkg::STEP_INTEG: begin
                    r_integ[w] <= inext;
                end
                dwsp_pkg::STEP_DRIVE: begin
                    r_last[w] <= r_err;
                    if (dshift > 29'(dwsp_pkg::DriveLimit)) begin
                        r_drive[w] <= 11'(dwsp_pkg::DriveLimit);
                    end else if (dshift < -29'(dwsp_pkg::DriveLimit)) begin
                        r_drive[w] <= -11'(dwsp_pkg::DriveLimit);
                    end else begin
                        r_drive[w] <= 11'(dshift);
                    end
                end
                dwsp_pkg::STEP_STOP: begin
                    for (int k = 0; k < 2; k++) begin
                        r_drive[k] <= '0;
                        r_integ[k] <= '0;
                        r_last[k]  <= '0;
                    end
                end
                dwsp_pkg::STEP_CLEAR: begin
                    for (int k = 0; k < 2; k++) begin
                        r_integ[k] <= '0;
                        r_last[k]  <= '0;
                    end
                    if ((i_target_right == 0) && (i_target_left == 0) && i_op) begin
                        r_ramp[0] <= '0;
                        r_ramp[1] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Accumulator: cleared by the first product step of the PID sum.
    always_ff @(posedge i_clk) begin
        case (i_cmd.step)
            dwsp_pkg::STEP_INTEG: r_acc <= '0;
            dwsp_pkg::STEP_KI:    r_acc <= r_acc + r_prod;
            dwsp_pkg::STEP_KD:    r_acc <= r_acc + r_prod;
            default:              r_acc <= r_acc;
        endcase
    end

    assign o_status.stop = r_stop;
    assign o_drive_right = r_drive[0];
    assign o_drive_left  = r_drive[1];
    assign o_speed_right = r_filt[0];
    assign o_speed_left  = r_filt[1];

endmodule

>>> src/dwsp_controller.sv
// ----------------------------------------------------------------------------
// dwsp_controller
// Sequences the datapath steps for one item and runs the handshakes.
// ----------------------------------------------------------------------------
module dwsp_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_op,
    output logic                  o_valid,
    input  logic                  i_ready,
    output dwsp_pkg::t_cmd        o_cmd,
    input  dwsp_pkg::t_status     i_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_RAW, S_FOLD, S_FNEW, S_RAMP, S_ERR, S_INTEG, S_KI,
        S_KD, S_DRIVE, S_STOP, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_wheel, n_wheel;
    logic   r_valid, n_valid;

    assign o_ready = (r_state == S_IDLE) && !r_valid;
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_wheel = r_wheel;
        n_valid = r_valid && !i_ready;
        o_cmd.step  = dwsp_pkg::STEP_NONE;
        o_cmd.wheel = r_wheel;
        o_cmd.load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load = 1'b1;
                    n_wheel = 1'b0;
                    if (i_op) begin
                        o_cmd.step = dwsp_pkg::STEP_CLEAR;
                    end else begin
                        n_state = S_RAW;
                    end
                end
            end
            S_RAW:   begin o_cmd.step = dwsp_pkg::STEP_RAW;   n_state = S_FOLD; end
            S_FOLD:  begin o_cmd.step = dwsp_pkg::STEP_FOLD;  n_state = S_FNEW; end
            S_FNEW: begin
                o_cmd.step = dwsp_pkg::STEP_FNEW;
                if (r_wheel) begin
                    n_state = S_RAMP;
                    n_wheel = 1'b0;
                end else begin
                    n_state = S_RAW;
                    n_wheel = 1'b1;
                end
            end
            S_RAMP:  begin o_cmd.step = dwsp_pkg::STEP_RAMP;  n_state = S_ERR; end
            S_ERR: begin
                o_cmd.step = dwsp_pkg::STEP_ERR;
                n_state = i_status.stop ? S_STOP : S_INTEG;
            end
            S_INTEG: begin o_cmd.step = dwsp_pkg::STEP_INTEG; n_state = S_KI; end
            S_KI:    begin o_cmd.step = dwsp_pkg::STEP_KI;    n_state = S_KD; end
            S_KD:    begin o_cmd.step = dwsp_pkg::STEP_KD;    n_state = S_DRIVE; end
            S_DRIVE: begin
                o_cmd.step = dwsp_pkg::STEP_DRIVE;
                if (r_wheel) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_ERR;
                    n_wheel = 1'b1;
                end
            end
            S_STOP:  begin o_cmd.step = dwsp_pkg::STEP_STOP;  n_state = S_OUT; end
            S_OUT: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wheel <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wheel <= n_wheel;
            r_valid <= n_valid;
        end
    end

endmodule
